// ===== hdl/f2pcm_pkg.sv =====
// Package for the float-to-PCM sample packer: format codes and register index.
// No dependencies.
`timescale 1ns / 1ps
package f2pcm_pkg;
    typedef enum logic [1:0] {
        FMT_PCM16 = 2'd0,
        FMT_PCM24 = 2'd1,
        FMT_FLT32 = 2'd2,
        FMT_RSVD  = 2'd3
    } fmt_t;

    localparam logic [0:0] REG_FORMAT = 1'b0;
endpackage

// ===== hdl/f2pcm_convert.sv =====
// Three-stage pipeline: decode float, shift and round, clamp, negate and select.
// Depends on f2pcm_pkg.
`timescale 1ns / 1ps
module f2pcm_convert (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [31:0]               in_bits,
    input  logic                      in_eob,
    input  f2pcm_pkg::fmt_t           in_fmt,
    output logic                      out_valid,
    output logic [31:0]               out_word,
    output logic [2:0]                out_count,
    output logic                      out_eob
);
    import f2pcm_pkg::*;

    // stage 1: decode
    logic        v1_reg;
    logic [31:0] bits1_reg;
    logic        eob1_reg, sign1_reg, inf1_reg, big1_reg, tiny1_reg;
    fmt_t        fmt1_reg;
    logic [23:0] man1_reg;
    logic        left1_reg;
    logic [4:0]  amt1_reg;

    logic [7:0]  ex;
    logic [23:0] man;
    logic [9:0]  sh;
    logic [4:0]  k;

    always_comb begin
        k   = (in_fmt == FMT_PCM24) ? 5'd23 : 5'd15;
        ex  = in_bits[30:23];
        man = {(ex != 8'd0), in_bits[22:0]};
        sh  = {2'b00, (ex == 8'd0) ? 8'd1 : ex} + {5'd0, k} - 10'd150;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
        end
        if (adv) begin
            bits1_reg <= in_bits;
            eob1_reg  <= in_eob;
            fmt1_reg  <= in_fmt;
            sign1_reg <= in_bits[31];
            inf1_reg  <= (ex == 8'hFF);
            man1_reg  <= man;
            left1_reg <= !sh[9];
            big1_reg  <= !sh[9] && (sh > 10'd16);
            tiny1_reg <= sh[9] && ((10'd0 - sh) >= 10'd26);
            amt1_reg  <= sh[9] ? 5'(10'd0 - sh) : 5'(sh);
        end
    end

    // stage 2: shift with rounding
    logic        v2_reg, eob2_reg, sign2_reg, zero2_reg, big2_reg;
    logic [31:0] bits2_reg;
    fmt_t        fmt2_reg;
    logic [40:0] mag2_reg;
    logic [40:0] mag;

    always_comb begin
        if (left1_reg) begin
            mag = {17'd0, man1_reg} << amt1_reg;
        end else begin
            mag = ({17'd0, man1_reg} + (41'd1 << (amt1_reg - 5'd1))) >> amt1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            bits2_reg <= bits1_reg;
            eob2_reg  <= eob1_reg;
            fmt2_reg  <= fmt1_reg;
            sign2_reg <= sign1_reg;
            zero2_reg <= inf1_reg || tiny1_reg;
            big2_reg  <= big1_reg;
            mag2_reg  <= mag;
        end
    end

    // stage 3: clamp, negate, select
    logic [40:0] full;
    logic [40:0] cl;
    logic [31:0] pcm;
    logic [31:0] word;
    logic [2:0]  cnt;

    always_comb begin
        full = (fmt2_reg == FMT_PCM24) ? (41'd1 << 23) : (41'd1 << 15);
        if (zero2_reg) begin
            cl = '0;
        end else if (big2_reg || mag2_reg > full) begin
            cl = full;
        end else begin
            cl = mag2_reg;
        end
        if (!sign2_reg && cl > full - 41'd1) begin
            cl = full - 41'd1;
        end
        pcm = sign2_reg ? (32'd0 - cl[31:0]) : cl[31:0];
        unique case (fmt2_reg)
            FMT_PCM16: begin word = pcm; cnt = 3'd2; end
            FMT_PCM24: begin word = pcm; cnt = 3'd3; end
            FMT_FLT32: begin word = bits2_reg; cnt = 3'd4; end
            default:   begin word = bits2_reg; cnt = 3'd4; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (adv) begin
            out_valid <= v2_reg;
        end
        if (adv) begin
            out_word  <= word;
            out_count <= cnt;
            out_eob   <= eob2_reg;
        end
    end
endmodule

// ===== hdl/float_to_pcm_sample_packer.sv =====
// Float sample to WAV byte packer: pipelined converter plus byte serializer.
// Sample in on s_axis, one byte per transaction on m_axis, format via APB.
// A sample passes the decode, round and clamp stages, then loads into the
// serializer. m_axis carries one byte per cycle while the receiver is ready;
// a sample gives 2, 3 or 4 bytes (PCM16, PCM24, float32).
// s_axis_tdata[31:0] is the float pattern, s_axis_tlast marks end of block.
// m_axis_tdata is one sample byte, LSB first; m_axis_tlast flags the final
// byte of each sample; m_axis_tuser flags that byte when the sample ended a
// block. The pipeline advances whenever its last stage is empty or being
// handed to the serializer, so a new sample enters while earlier ones still
// convert. When the receiver stalls, the current byte holds and the pipeline
// fills then stops; nothing is dropped or repeated. Reset clears all valid
// bits and sets sample_format to PCM16. Write sample_format only when idle.
`timescale 1ns / 1ps
module float_to_pcm_sample_packer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_bits
    input  logic        s_axis_tlast,   // end_of_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // data_byte
    output logic        m_axis_tlast,   // last_of_sample
    output logic        m_axis_tuser,   // block_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import f2pcm_pkg::*;

    fmt_t fmt_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FORMAT) ? {30'd0, fmt_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_PCM16;
        end else if (psel && penable && pwrite && paddr == REG_FORMAT) begin
            fmt_reg <= fmt_t'(pwdata[1:0]);
        end
    end

    logic        c_valid, c_eob;
    logic [31:0] c_word;
    logic [2:0]  c_count;
    logic        adv, load;

    // serializer
    logic        busy_reg;
    logic [31:0] word_reg;
    logic [2:0]  left_reg;
    logic        eob_reg;

    logic ser_free;
    assign ser_free = !busy_reg || (m_axis_tready && left_reg == 3'd1);
    assign load     = c_valid && ser_free;
    assign adv      = !c_valid || ser_free;
    assign s_axis_tready = adv;

    f2pcm_convert u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .in_bits   (s_axis_tdata),
        .in_eob    (s_axis_tlast),
        .in_fmt    (fmt_reg),
        .out_valid (c_valid),
        .out_word  (c_word),
        .out_count (c_count),
        .out_eob   (c_eob)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            left_reg <= 3'd0;
        end else if (load) begin
            busy_reg <= 1'b1;
            left_reg <= c_count;
        end else if (busy_reg && m_axis_tready) begin
            left_reg <= left_reg - 3'd1;
            busy_reg <= (left_reg != 3'd1);
        end
        if (load) begin
            word_reg <= c_word;
            eob_reg  <= c_eob;
        end else if (busy_reg && m_axis_tready) begin
            word_reg <= {8'd0, word_reg[31:8]};
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = word_reg[7:0];
    assign m_axis_tlast  = (left_reg == 3'd1);
    assign m_axis_tuser  = (left_reg == 3'd1) && eob_reg;
endmodule

// ===== tb/sv/float_to_pcm_sample_packer_test.sv =====
// Testbench for float_to_pcm_sample_packer: directed table plus random samples,
// every byte checked against a local encoder. Depends on f2pcm_pkg and the RTL.
`timescale 1ns / 1ps
module float_to_pcm_sample_packer_test;
    import f2pcm_pkg::*;

    typedef struct {
        fmt_t        fmt;
        logic [31:0] bits;
        logic        eob;
        logic        known;  // word below is typed in and checked as well
        logic [31:0] word;
    } sample_row_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       done;
    } pcm_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // sample_bits
    logic        s_axis_tlast = 1'b0; // end_of_block
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // data_byte
    logic        m_axis_tlast;        // last_of_sample
    logic        m_axis_tuser;        // block_done
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pcm_byte_t   pending_bytes[$];
    fmt_t        cur_fmt = FMT_PCM16;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          rx_stall = 0;
    bit          no_gaps = 1'b0;
    bit          no_stalls = 1'b0;

    localparam int WATCHDOG_LIMIT = 3000;

    float_to_pcm_sample_packer DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Scale by 2^k, round half away from zero, clamp, two's complement.
    function automatic logic [31:0] pcm_word(logic [31:0] bits, int k);
        logic [63:0] full;
        logic [63:0] mag;
        logic [63:0] man;
        int ex;
        int sh;
        int n;
        full = 64'd1 << k;
        ex = bits[30:23];
        man = {41'd0, bits[22:0]};
        if (ex == 255) return '0;
        if (ex != 0) man = man | 64'h800000;
        else ex = 1;
        sh = ex - 150 + k;
        if (sh >= 0) begin
            mag = (sh > 16) ? full : (man << sh);
        end else begin
            n = -sh;
            mag = (n >= 26) ? 64'd0 : ((man + (64'd1 << (n - 1))) >> n);
        end
        if (!bits[31]) return (mag > full - 1) ? full[31:0] - 1 : mag[31:0];
        if (mag > full) mag = full;
        return 32'd0 - mag[31:0];
    endfunction

    function automatic int byte_count(fmt_t f);
        case (f)
            FMT_PCM16: return 2;
            FMT_PCM24: return 3;
            default:   return 4;
        endcase
    endfunction

    function automatic logic [31:0] encode_sample(fmt_t f, logic [31:0] bits);
        case (f)
            FMT_PCM16: return pcm_word(bits, 15);
            FMT_PCM24: return pcm_word(bits, 23);
            default:   return bits;
        endcase
    endfunction

    task automatic report(string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic queue_sample_bytes(logic [31:0] word, logic eob);
        int cnt;
        pcm_byte_t b;
        cnt = byte_count(cur_fmt);
        for (int j = 0; j < cnt; j++) begin
            b.data = word[j*8 +: 8];
            b.last = (j == cnt - 1);
            b.done = (j == cnt - 1) && eob;
            pending_bytes.insert(pending_bytes.size(), b);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Present one sample and hold it until the block takes it.
    task automatic send_sample(logic [31:0] bits, logic eob);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        s_axis_tlast  <= eob;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        queue_sample_bytes(encode_sample(cur_fmt, bits), eob);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_format(fmt_t f);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_FORMAT;
        pwdata  <= {30'd0, f};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_fmt = f;
        @(posedge aclk);
    endtask

    // Receiver: random stalls, mostly short, some long.
    always @(posedge aclk) begin
        if (no_stalls) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                rx_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                         : $urandom_range(1, 3);
        end
    end

    // Compare each byte transaction with the oldest expectation.
    always @(posedge aclk) begin
        pcm_byte_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h", m_axis_tdata));
            end else begin
                e = pending_bytes.pop_front();
                if (m_axis_tdata !== e.data)
                    report($sformatf("data %02h, want %02h", m_axis_tdata, e.data));
                if (m_axis_tlast !== e.last)
                    report($sformatf("tlast %b, want %b", m_axis_tlast, e.last));
                if (m_axis_tuser !== e.done)
                    report($sformatf("tuser %b, want %b", m_axis_tuser, e.done));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    sample_row_t directed_rows[] = '{
        '{FMT_PCM16, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
        '{FMT_PCM16, 32'h3F80_0000, 1'b0, 1'b1, 32'h0000_7FFF},  // +1.0 clamps
        '{FMT_PCM16, 32'hBF80_0000, 1'b1, 1'b1, 32'hFFFF_8000},  // -1.0
        '{FMT_PCM16, 32'h7F80_0000, 1'b0, 1'b1, 32'h0000_0000},  // +inf
        '{FMT_PCM16, 32'hFF80_0000, 1'b0, 1'b1, 32'h0000_0000},  // -inf
        '{FMT_PCM16, 32'h7FC0_0000, 1'b1, 1'b1, 32'h0000_0000},  // NaN
        '{FMT_PCM16, 32'h8000_0000, 1'b0, 1'b1, 32'h0000_0000},  // negative zero
        '{FMT_PCM16, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000},  // subnormal
        '{FMT_PCM16, 32'h7F7F_FFFF, 1'b0, 1'b1, 32'h0000_7FFF},
        '{FMT_PCM16, 32'hFF7F_FFFF, 1'b0, 1'b1, 32'hFFFF_8000},
        '{FMT_PCM16, 32'h3F00_0000, 1'b0, 1'b1, 32'h0000_4000},
        '{FMT_PCM16, 32'h3780_0000, 1'b0, 1'b1, 32'h0000_0001},  // tie rounds up
        '{FMT_PCM16, 32'hB780_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},  // tie rounds down
        '{FMT_PCM24, 32'h3F80_0000, 1'b0, 1'b1, 32'h007F_FFFF},
        '{FMT_PCM24, 32'hBF80_0000, 1'b0, 1'b1, 32'hFF80_0000},
        '{FMT_PCM24, 32'h3F00_0000, 1'b0, 1'b1, 32'h0040_0000},
        '{FMT_PCM24, 32'h3380_0000, 1'b1, 1'b1, 32'h0000_0001},
        '{FMT_PCM24, 32'hBEAA_AAAB, 1'b0, 1'b0, 32'h0},
        '{FMT_PCM24, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
        '{FMT_FLT32, 32'hDEAD_BEEF, 1'b0, 1'b1, 32'hDEAD_BEEF},
        '{FMT_FLT32, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{FMT_RSVD,  32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678},
        '{FMT_RSVD,  32'h7FC0_0001, 1'b1, 1'b1, 32'h7FC0_0001}
    };

    function automatic logic [31:0] random_sample();
        logic [31:0] v;
        v = $urandom();
        // Keep most exponents near full scale, where rounding and clamping live.
        if ($urandom_range(0, 99) < 70) v[30:23] = $urandom_range(100, 130);
        return v;
    endfunction

    initial begin
        fmt_t f;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].fmt != cur_fmt) begin
                drain();
                write_format(directed_rows[i].fmt);
            end
            if (directed_rows[i].known &&
                encode_sample(cur_fmt, directed_rows[i].bits) !== directed_rows[i].word)
                report($sformatf("encoder gives %08h for %08h, table says %08h",
                                 encode_sample(cur_fmt, directed_rows[i].bits),
                                 directed_rows[i].bits, directed_rows[i].word));
            send_sample(directed_rows[i].bits, directed_rows[i].eob);
        end

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            f = fmt_t'(phase % 4);
            write_format(f);
            no_gaps   = (phase == 2);
            no_stalls = (phase == 5);
            for (int i = 0; i < 17; i++) begin
                if (phase == 3 && i == 10) drain();  // hold off until all bytes are out
                send_sample(random_sample(), $urandom_range(0, 3) == 0);
            end
        end
        no_gaps = 1'b0;
        no_stalls = 1'b0;
        drain();
        write_format(FMT_PCM16);

        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
